/* design/assert_macros.svh */
// assertion helpers for the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a implies condition c at the same clock edge
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication check failed");

// condition a must never hold
`define ASSERT_NEVER(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
		else $error("forbidden condition seen");

`endif

/* design/wwrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwrp_pkg
// shared types and constants of the whitespace word record packer
// ----------------------------------------------------------------------------
package wwrp_pkg;

	localparam int BYTE_W    = 8;
	localparam int FILL_W    = 7;
	localparam int CFG_IDX_W = 4;

	// register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_CODE       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_SPACE_CODE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_CODE       = 4'd3;

	// special characters
	localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

	// reset values of the config registers
	localparam logic [FILL_W-1:0] RST_RECORD_LENGTH  = 7'd16;
	localparam logic [BYTE_W-1:0] RST_PAD_CODE       = 8'd0;
	localparam logic [BYTE_W-1:0] RST_END_SPACE_CODE = 8'd1;
	localparam logic [BYTE_W-1:0] RST_END_CODE       = 8'd2;

	// one closed word waiting for the back end
	typedef struct packed {
		logic              bank;
		logic [FILL_W-1:0] fill;
		logic              space;
		logic              done;
	} cmd_t;

	// back end hands a word bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_RUN  = 2'b10
	} back_state_t;

	function automatic logic is_white(input logic [BYTE_W-1:0] b);
		return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
	endfunction

endpackage

/* design/wwrp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwrp_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wwrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/wwrp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwrp_front
// takes text bytes, fills the word banks and posts closed words
// ----------------------------------------------------------------------------
module wwrp_front #(
	parameter int MAX_RECORD = 64,
	parameter int IW         = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [wwrp_pkg::BYTE_W-1:0] text_byte,
	input  logic                       fifo_full,
	output logic                       cmd_push,
	output wwrp_pkg::cmd_t             cmd,
	input  wwrp_pkg::release_t         rel,
	output logic [1:0]                 busy,
	output logic                       ram_we,
	output logic [IW:0]                ram_waddr,
	output logic [wwrp_pkg::BYTE_W-1:0] ram_wdata
);

	logic [wwrp_pkg::FILL_W-1:0] fill_q;
	logic [wwrp_pkg::FILL_W-1:0] fill_next;
	logic                        bank_q;
	logic [1:0]                  busy_q;
	logic                        accept;
	logic                        is_zero;
	logic                        keep;
	logic                        close;

	assign in_ready  = !busy_q[bank_q] && !fifo_full;
	assign accept    = in_valid && in_ready;
	assign is_zero   = (text_byte == wwrp_pkg::CHAR_NUL);
	assign keep      = !is_zero && (fill_q < wwrp_pkg::FILL_W'(MAX_RECORD));
	assign close     = is_zero || wwrp_pkg::is_white(text_byte);
	assign fill_next = keep ? fill_q + wwrp_pkg::FILL_W'(1) : fill_q;

	assign ram_we    = accept && keep;
	assign ram_waddr = {bank_q, fill_q[IW-1:0]};
	assign ram_wdata = text_byte;

	assign cmd_push  = accept && close;
	assign cmd.bank  = bank_q;
	assign cmd.fill  = fill_next;
	assign cmd.space = (text_byte == wwrp_pkg::CHAR_SPACE);
	assign cmd.done  = is_zero;

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			if (accept) begin
				if (close) begin
					fill_q <= '0;
					bank_q <= ~bank_q;
				end else begin
					fill_q <= fill_next;
				end
			end
			for (int i = 0; i < 2; i++) begin
				if (cmd_push && (bank_q == 1'(i))) begin
					busy_q[i] <= 1'b1;
				end else if (rel.valid && (rel.bank == 1'(i))) begin
					busy_q[i] <= 1'b0;
				end
			end
		end
	end

endmodule

/* design/wwrp_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwrp_cmd_fifo
// two entry queue of closed words between front and back end
// ----------------------------------------------------------------------------
module wwrp_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wwrp_pkg::cmd_t wr_data,
	input  logic           pop,
	output wwrp_pkg::cmd_t rd_data,
	output logic           full,
	output logic           empty
);

	wwrp_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* design/wwrp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwrp_back
// plays out one record per closed word, one byte per cycle while out_ready allows
// ----------------------------------------------------------------------------
module wwrp_back #(
	parameter int MAX_RECORD = 64,
	parameter int IW         = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fifo_empty,
	input  wwrp_pkg::cmd_t              cmd,
	output logic                        fifo_pop,
	input  logic [wwrp_pkg::FILL_W-1:0] record_length,
	input  logic [wwrp_pkg::BYTE_W-1:0] pad_code,
	input  logic [wwrp_pkg::BYTE_W-1:0] end_space_code,
	input  logic [wwrp_pkg::BYTE_W-1:0] end_code,
	output logic                        ram_re,
	output logic [IW:0]                 ram_raddr,
	input  logic [wwrp_pkg::BYTE_W-1:0] ram_rdata,
	output wwrp_pkg::release_t          rel,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [wwrp_pkg::BYTE_W-1:0] record_byte,
	output logic                        record_last,
	output logic                        text_done
);

	localparam logic [wwrp_pkg::FILL_W-1:0] MAX_LEN = wwrp_pkg::FILL_W'(MAX_RECORD);

	wwrp_pkg::back_state_t       state_q;
	logic                        bank_q;
	logic [wwrp_pkg::FILL_W-1:0] pos_q;
	logic [wwrp_pkg::FILL_W-1:0] len_q;
	logic [wwrp_pkg::FILL_W-1:0] kept_q;
	logic [wwrp_pkg::BYTE_W-1:0] marker_q;
	logic                        done_q;

	logic [wwrp_pkg::FILL_W-1:0] eff_len;
	logic [wwrp_pkg::FILL_W-1:0] len_m1;

	logic                        valid_s1;
	logic                        word_s1;
	logic [wwrp_pkg::BYTE_W-1:0] byte_s1;
	logic                        last_s1;
	logic                        done_s1;

	logic                        out_valid_q;
	logic [wwrp_pkg::BYTE_W-1:0] out_byte_q;
	logic                        out_last_q;
	logic                        out_done_q;

	logic                        out_load;
	logic                        advance;
	logic                        issue;
	logic                        last_issue;
	logic                        is_word;

	// clamp record length into 1..MAX_RECORD
	always_comb begin
		if (record_length == '0) begin
			eff_len = wwrp_pkg::FILL_W'(1);
		end else if (record_length > MAX_LEN) begin
			eff_len = MAX_LEN;
		end else begin
			eff_len = record_length;
		end
	end

	assign fifo_pop   = (state_q == wwrp_pkg::BK_IDLE) && !fifo_empty;
	assign out_load   = valid_s1 && (!out_valid_q || out_ready);
	assign advance    = !valid_s1 || out_load;
	assign issue      = (state_q == wwrp_pkg::BK_RUN) && advance;
	assign len_m1     = len_q - wwrp_pkg::FILL_W'(1);
	assign last_issue = (pos_q == len_m1);
	assign is_word    = (pos_q < kept_q);

	assign ram_re    = issue;
	assign ram_raddr = {bank_q, pos_q[IW-1:0]};

	assign rel.valid = issue && last_issue;
	assign rel.bank  = bank_q;

	assign out_valid   = out_valid_q;
	assign record_byte = out_byte_q;
	assign record_last = out_last_q;
	assign text_done   = out_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wwrp_pkg::BK_IDLE;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				wwrp_pkg::BK_IDLE: begin
					if (fifo_pop) begin
						state_q <= wwrp_pkg::BK_RUN;
					end
				end
				wwrp_pkg::BK_RUN: begin
					if (issue && last_issue) begin
						state_q <= wwrp_pkg::BK_IDLE;
					end
				end
				default: begin
					state_q <= wwrp_pkg::BK_IDLE;
				end
			endcase
			if (advance) begin
				valid_s1 <= issue;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			bank_q   <= cmd.bank;
			pos_q    <= '0;
			len_q    <= eff_len;
			kept_q   <= (cmd.fill < eff_len) ? cmd.fill : eff_len;
			marker_q <= (cmd.space && !cmd.done) ? end_space_code : end_code;
			done_q   <= cmd.done;
		end else if (issue) begin
			pos_q <= pos_q + wwrp_pkg::FILL_W'(1);
		end
		if (issue) begin
			word_s1 <= is_word;
			byte_s1 <= (pos_q == kept_q) ? marker_q : pad_code;
			last_s1 <= last_issue;
			done_s1 <= done_q;
		end
		if (out_load) begin
			out_byte_q <= word_s1 ? ram_rdata : byte_s1;
			out_last_q <= last_s1;
			out_done_q <= done_s1;
		end
	end

endmodule

/* design/whitespace_word_record_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whitespace_word_record_packer
// cuts a text byte stream into words and emits fixed length records
// ----------------------------------------------------------------------------
// first record byte: via the queue, back end pop, ram read, then output register
// throughput: one text byte per cycle, stalled while the current word bank waits
//   for the back end; records leave one byte per cycle from the single ram read
//   port unless out_ready stalls, with an idle state to pop the next word
// reset: async active low; clears fill count, banks, queue, output register and
//   loads the config defaults; word ram needs no clearing pass
module whitespace_word_record_packer #(
	parameter int MAX_RECORD = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// text byte requests
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [wwrp_pkg::BYTE_W-1:0]    text_byte,
	// record byte requests
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [wwrp_pkg::BYTE_W-1:0]    record_byte,
	output logic                           record_last,
	output logic                           text_done,
	// config writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wwrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wwrp_pkg::BYTE_W-1:0]    cfg_data
);

	`include "assert_macros.svh"

	// word index bits; the ram holds two banks of 2**IW bytes, each at least MAX_RECORD
	localparam int IW        = $clog2(MAX_RECORD);
	localparam int RAM_DEPTH = 2 * (2 ** IW);

	// config registers
	logic [wwrp_pkg::FILL_W-1:0] record_length_q;
	logic [wwrp_pkg::BYTE_W-1:0] pad_code_q;
	logic [wwrp_pkg::BYTE_W-1:0] end_space_code_q;
	logic [wwrp_pkg::BYTE_W-1:0] end_code_q;
	logic                        cfg_write;

	// front to queue
	logic                        cmd_push;
	wwrp_pkg::cmd_t              cmd_in;
	logic                        fifo_full;
	// queue to back
	logic                        fifo_pop;
	logic                        fifo_empty;
	wwrp_pkg::cmd_t              cmd_head;
	// bank handback and occupancy
	wwrp_pkg::release_t          rel;
	logic [1:0]                  busy;

	// word ram ports
	logic                        ram_we;
	logic [IW:0]                 ram_waddr;
	logic [wwrp_pkg::BYTE_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [IW:0]                 ram_raddr;
	logic [wwrp_pkg::BYTE_W-1:0] ram_rdata;

	// config port always takes a write; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_length_q  <= wwrp_pkg::RST_RECORD_LENGTH;
			pad_code_q       <= wwrp_pkg::RST_PAD_CODE;
			end_space_code_q <= wwrp_pkg::RST_END_SPACE_CODE;
			end_code_q       <= wwrp_pkg::RST_END_CODE;
		end else if (cfg_write) begin
			case (cfg_index)
				wwrp_pkg::REG_RECORD_LENGTH: begin
					record_length_q <= cfg_data[wwrp_pkg::FILL_W-1:0];
				end
				wwrp_pkg::REG_PAD_CODE: begin
					pad_code_q <= cfg_data;
				end
				wwrp_pkg::REG_END_SPACE_CODE: begin
					end_space_code_q <= cfg_data;
				end
				wwrp_pkg::REG_END_CODE: begin
					end_code_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// front end: stores word bytes and closing whitespace in its current bank, posts closed words
	wwrp_front #(
		.MAX_RECORD (MAX_RECORD),
		.IW         (IW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.text_byte (text_byte),
		.fifo_full (fifo_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.rel       (rel),
		.busy      (busy),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	// closed words waiting for playout
	wwrp_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_in),
		.pop     (fifo_pop),
		.rd_data (cmd_head),
		.full    (fifo_full),
		.empty   (fifo_empty)
	);

	// word store, two banks so the next word fills while one plays out
	wwrp_ram #(
		.WIDTH (wwrp_pkg::BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_word_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// back end: word bytes, marker, then pad, through an output register
	wwrp_back #(
		.MAX_RECORD (MAX_RECORD),
		.IW         (IW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.fifo_empty     (fifo_empty),
		.cmd            (cmd_head),
		.fifo_pop       (fifo_pop),
		.record_length  (record_length_q),
		.pad_code       (pad_code_q),
		.end_space_code (end_space_code_q),
		.end_code       (end_code_q),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.rel            (rel),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.record_byte    (record_byte),
		.record_last    (record_last),
		.text_done      (text_done)
	);

	// queue never overflows or underflows
	`ASSERT_NEVER(a_fifo_overflow, clk, arst_n, cmd_push && fifo_full)
	`ASSERT_NEVER(a_fifo_underflow, clk, arst_n, fifo_pop && fifo_empty)
	// a bank handed back was claimed by a posted word
	`ASSERT_IMPLY(a_release_busy, clk, arst_n, rel.valid, busy[rel.bank])

endmodule
